>>> rtl/nge_pkg.sv
// Shared constants and types for the noise gate and pre-emphasis block.
package nge_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_FRAC_BITS_DEF = 15;

    // Coefficient after reset (0.97 in Q15), cut to the fraction width
    localparam logic [31:0] COEF_RESET = 32'd31784;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 1;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_GATE_THRESHOLD      = 1'b0;
    localparam cfg_index_t REG_EMPHASIS_COEFFICIENT = 1'b1;

endpackage

>>> rtl/nge_datapath.sv
// Gate and pre-emphasis arithmetic for one sample, purely combinational.
module nge_datapath #(
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_FRAC_BITS = 15
) (
    input  logic signed [SAMPLE_BITS-1:0]    sample,
    input  logic        [SAMPLE_BITS-1:0]    threshold,
    input  logic        [COEF_FRAC_BITS-1:0] coef,
    input  logic signed [SAMPLE_BITS-1:0]    prev,
    output logic signed [SAMPLE_BITS-1:0]    gated,
    output logic signed [SAMPLE_BITS-1:0]    result
);

    localparam int S = SAMPLE_BITS;
    localparam int F = COEF_FRAC_BITS;
    localparam int P = S + F + 1;

    logic signed [S:0]   sample_ext;
    logic        [S:0]   magnitude;
    logic                below;
    logic signed [F:0]   coef_s;
    logic signed [P-1:0] product;
    logic signed [P-1:0] product_shr;
    logic signed [S:0]   scaled;
    logic signed [S+1:0] diff;
    logic                overflow;

    // Magnitude, with the most negative code giving 2^(S-1)
    assign sample_ext = (S+1)'(sample);
    assign magnitude  = sample_ext[S] ? unsigned'(-sample_ext) : unsigned'(sample_ext);
    assign below      = magnitude < {1'b0, threshold};
    assign gated      = below ? '0 : sample;

    // Scale the previous gated sample, floor through arithmetic shift
    assign coef_s      = signed'({1'b0, coef});
    assign product     = P'(coef_s) * P'(prev);
    assign product_shr = product >>> F;
    assign scaled      = signed'(product_shr[S:0]);

    // Subtract and clamp to the sample range
    assign diff     = (S+2)'(gated) - (S+2)'(scaled);
    assign overflow = (diff[S+1:S-1] != '0) && (diff[S+1:S-1] != '1);

    always_comb
    begin
        if (overflow)
        begin
            result = diff[S+1] ? signed'({1'b1, {(S-1){1'b0}}})
                               : signed'({1'b0, {(S-1){1'b1}}});
        end
        else
        begin
            result = signed'(diff[S-1:0]);
        end
    end

endmodule

>>> rtl/noise_gate_pre_emphasis.sv
// Top level: noise gate followed by first-order pre-emphasis on a sample stream.
//
// Each input word carries one signed sample; samples whose magnitude is below
// the gate threshold are zeroed, then y = x - ((coef * previous) >>> frac_bits)
// is formed and saturated to the sample range, one output word per input word.
// The block takes one word per clock and gives one word per clock while the
// output is not back-pressured; an accepted sample sits in the input register
// and moves to the output register once the output slot is free, so the input
// register and the output register around the single multiply-subtract-clamp
// path lie between the input stream and the output stream.
// Back-pressure on the output stalls the output register first; the
// input register still takes a word while it is empty. Write
// configuration registers only while no words are in flight.
module noise_gate_pre_emphasis #(
    parameter int SAMPLE_BITS    = nge_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = nge_pkg::COEF_FRAC_BITS_DEF,
    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int CFG_W   = (SAMPLE_BITS > COEF_FRAC_BITS) ? SAMPLE_BITS : COEF_FRAC_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration write port
    input  logic                     cfg_wr_en,
    input  nge_pkg::cfg_index_t      cfg_index,
    input  logic [CFG_W-1:0]         cfg_wr_data,
    // Input stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [TDATA_W-1:0]       s_axis_tdata,   // sample_in, zero padded above
    // Output stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [TDATA_W-1:0]       m_axis_tdata    // sample_out, zero padded above
);

    import nge_pkg::*;

    logic                             in_valid_reg;
    logic                             in_valid_next;
    logic signed [SAMPLE_BITS-1:0]    in_sample_reg;
    logic signed [SAMPLE_BITS-1:0]    in_sample_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic signed [SAMPLE_BITS-1:0]    out_sample_reg;
    logic signed [SAMPLE_BITS-1:0]    out_sample_next;
    logic signed [SAMPLE_BITS-1:0]    prev_reg;
    logic signed [SAMPLE_BITS-1:0]    prev_next;
    logic        [SAMPLE_BITS-1:0]    threshold_reg;
    logic        [SAMPLE_BITS-1:0]    threshold_next;
    logic        [COEF_FRAC_BITS-1:0] coef_reg;
    logic        [COEF_FRAC_BITS-1:0] coef_next;

    logic                             out_free;
    logic                             advance;
    logic                             in_fire;
    logic signed [SAMPLE_BITS-1:0]    gated;
    logic signed [SAMPLE_BITS-1:0]    result;

    // Handshake: output slot frees when empty or taken this cycle
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(unsigned'(out_sample_reg));

    // Arithmetic between the input and output registers
    nge_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .sample    (in_sample_reg),
        .threshold (threshold_reg),
        .coef      (coef_reg),
        .prev      (prev_reg),
        .gated     (gated),
        .result    (result)
    );

    // Pipeline next values
    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_sample_next  = in_sample_reg;
        out_valid_next  = out_valid_reg;
        out_sample_next = out_sample_reg;
        prev_next       = prev_reg;

        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
        if (advance)
        begin
            out_sample_next = result;
            prev_next       = gated;
        end
        if (in_fire)
        begin
            in_valid_next  = 1'b1;
            in_sample_next = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Configuration register writes
    always_comb
    begin
        threshold_next = threshold_reg;
        coef_next      = coef_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GATE_THRESHOLD:       threshold_next = cfg_wr_data[SAMPLE_BITS-1:0];
                REG_EMPHASIS_COEFFICIENT: coef_next      = cfg_wr_data[COEF_FRAC_BITS-1:0];
            endcase
        end
    end

    // Control state, filter state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            threshold_reg <= '0;
            coef_reg      <= COEF_RESET[COEF_FRAC_BITS-1:0];
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            threshold_reg <= threshold_next;
            coef_reg      <= coef_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_sample_reg  <= in_sample_next;
        out_sample_reg <= out_sample_next;
    end

endmodule

>>> rtl/nge_checker.sv
// Port-level checks for the noise gate and pre-emphasis block, bound to the top level.
module nge_port_checks #(
    parameter int TDATA_W = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // Hold a stalled output word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output word changed");

    // Drop input ready only when the output is full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without output back-pressure");

    // Output valid is high once an accepted word has had time to pass the input and output registers
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted word did not reach the output");

    // No output word while reset is held; valid may still be unknown at the first edge
    assert property (@(posedge clk)
        !rst_n |-> m_axis_tvalid !== 1'b1)
        else $error("output valid during reset");

endmodule

bind noise_gate_pre_emphasis nge_port_checks #(
    .TDATA_W (TDATA_W)
) u_nge_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
